### hw/rtl/pgs_pkg.sv
// pgs_pkg: shared constants, types and helpers of the palette gradient sampler
// no dependencies; imported by every module of the block except pgs_ram
`timescale 1ns / 1ps
`default_nettype none

package pgs_pkg;

    // palette geometry
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);

    // field widths
    localparam int CH_W     = 8;
    localparam int COLOR_W  = 3 * CH_W;
    localparam int IDX_W    = 8;
    localparam int SAMPLE_W = 24;
    localparam int WRAP_W   = 16;
    localparam int SPAN_W   = 9;
    localparam int FRAC_W   = 16;
    localparam int OUT_W    = 32;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_WRAP_FACTOR    = 1'b0;
    localparam logic REG_ENTRIES_IN_USE = 1'b1;

    localparam logic [WRAP_W-1:0] WRAP_RESET = 16'd3840;
    localparam logic [SPAN_W-1:0] SPAN_RESET = 9'd256;
    localparam logic [CH_W-1:0]   ALPHA      = 8'hFF;

    // opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // input word as taken from the ports
    typedef struct packed {
        logic                opcode;
        logic [IDX_W-1:0]    entry_index;
        logic [CH_W-1:0]     red;
        logic [CH_W-1:0]     green;
        logic [CH_W-1:0]     blue;
        logic [SAMPLE_W-1:0] sample_value;
    } in_item_t;

    // after the wrap multiply
    typedef struct packed {
        logic               is_sample;
        logic               wr_en;
        logic [PAL_AW-1:0]  wr_addr;
        logic [COLOR_W-1:0] wr_data;
        logic [FRAC_W-1:0]  wrapped;
    } wrap_item_t;

    // after the span multiply, ready for the palette lookup
    typedef struct packed {
        logic               is_sample;
        logic               wr_en;
        logic [PAL_AW-1:0]  wr_addr;
        logic [COLOR_W-1:0] wr_data;
        logic [PAL_AW-1:0]  lower;
        logic [FRAC_W-1:0]  frac;
    } map_item_t;

    // entries in use, clamped to [1, PAL_DEPTH], minus one
    function automatic logic [PAL_AW-1:0] span_minus_one(input logic [SPAN_W-1:0] n);
        logic [PAL_AW-1:0] r;
        if (n == '0) begin
            r = '0;
        end else if (32'(n) > 32'(PAL_DEPTH)) begin
            r = PAL_AW'(PAL_DEPTH - 1);
        end else begin
            r = PAL_AW'(32'(n) - 32'd1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/pgs_ram.sv
// pgs_ram: generic RAM, one write port and two registered read ports
// standalone, no package dependency
`timescale 1ns / 1ps
`default_nettype none

module pgs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read ports, output held while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pgs_map.sv
// pgs_map: two pipeline stages, wrap multiply then span multiply
// depends on pgs_pkg
`timescale 1ns / 1ps
`default_nettype none

module pgs_map (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire pgs_pkg::in_item_t          in_item,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output pgs_pkg::map_item_t              out_item,
    input  wire logic [pgs_pkg::WRAP_W-1:0] wrap_factor,
    input  wire logic [pgs_pkg::SPAN_W-1:0] entries_in_use
);
    import pgs_pkg::*;

    logic       s1_valid_reg, s2_valid_reg;
    wrap_item_t s1_reg, s1_next;
    map_item_t  s2_reg, s2_next;
    logic       en1, en2;
    logic [SAMPLE_W+WRAP_W-1:0] product;
    logic [PAL_AW+FRAC_W-1:0]   position;

    // stage enables: a stage loads when empty or when its word moves on
    assign en2      = !s2_valid_reg || out_ready;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    // stage 1: sample times wrap factor, keep the fraction
    always_comb begin
        product           = (SAMPLE_W+WRAP_W)'(in_item.sample_value)
                          * (SAMPLE_W+WRAP_W)'(wrap_factor);
        s1_next.is_sample = (in_item.opcode == OP_SAMPLE);
        s1_next.wr_en     = (in_item.opcode == OP_WRITE)
                          && (32'(in_item.entry_index) < 32'(PAL_DEPTH));
        s1_next.wr_addr   = PAL_AW'(in_item.entry_index);
        s1_next.wr_data   = {in_item.blue, in_item.green, in_item.red};
        s1_next.wrapped   = product[FRAC_W+7:8];
    end

    // stage 2: scale by span minus one into index and blend fraction
    always_comb begin
        position          = (PAL_AW+FRAC_W)'(span_minus_one(entries_in_use))
                          * (PAL_AW+FRAC_W)'(s1_reg.wrapped);
        s2_next.is_sample = s1_reg.is_sample;
        s2_next.wr_en     = s1_reg.wr_en;
        s2_next.wr_addr   = s1_reg.wr_addr;
        s2_next.wr_data   = s1_reg.wr_data;
        s2_next.lower     = position[PAL_AW+FRAC_W-1:FRAC_W];
        s2_next.frac      = position[FRAC_W-1:0];
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                s1_valid_reg <= in_valid;
            end
            if (en2) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_reg <= s1_next;
        end
        if (en2) begin
            s2_reg <= s2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_reg;

endmodule

`default_nettype wire

### hw/rtl/pgs_blend.sv
// pgs_blend: per-channel linear blend and packed output register
// depends on pgs_pkg
`timescale 1ns / 1ps
`default_nettype none

module pgs_blend (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [pgs_pkg::COLOR_W-1:0] color_lo,
    input  wire logic [pgs_pkg::COLOR_W-1:0] color_hi,
    input  wire logic [pgs_pkg::FRAC_W-1:0]  frac,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [pgs_pkg::OUT_W-1:0]   out_color
);
    import pgs_pkg::*;

    localparam int SUM_W = CH_W + FRAC_W + 2;

    logic                valid_reg;
    logic [OUT_W-1:0]    color_reg, color_next;
    logic [COLOR_W-1:0]  mix;

    // lo + (hi - lo) * frac, same as lo * (1 - frac) + hi * frac
    // every operand is widened to the full sum width before the multiply
    function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0]   a,
                                                    input logic [CH_W-1:0]   b,
                                                    input logic [FRAC_W-1:0] f);
        logic signed [SUM_W-1:0] diff;
        logic signed [SUM_W-1:0] weight;
        logic signed [SUM_W-1:0] sum;
        diff   = $signed(SUM_W'({1'b0, b})) - $signed(SUM_W'({1'b0, a}));
        weight = $signed(SUM_W'(f));
        sum    = $signed(SUM_W'({a, {FRAC_W{1'b0}}})) + diff * weight;
        return sum[CH_W+FRAC_W-1:FRAC_W];
    endfunction

    // three channels in parallel
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            mix[c*CH_W +: CH_W] = mix_channel(color_lo[c*CH_W +: CH_W],
                                              color_hi[c*CH_W +: CH_W], frac);
        end
        color_next = {ALPHA, mix};
    end

    assign in_ready = !valid_reg || out_ready;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            color_reg <= color_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_color = color_reg;

endmodule

`default_nettype wire

### hw/rtl/palette_gradient_sample_core.sv
// palette_gradient_sample_core: top level of the palette gradient sampler
// depends on pgs_pkg, pgs_map, pgs_ram, pgs_blend
//
//  channel  | ports                                   | word
//  ---------+-----------------------------------------+----------------------------
//  input    | s_valid / s_ready                       | opcode, entry, rgb, sample
//  result   | m_valid / m_ready                       | packed_color, one per sample
//  config   | psel penable pwrite paddr pwdata prdata | wrap_factor @0, entries @4
//
// one word accepted per cycle while no stall on m_ready backs up; a sample reaches m_valid
// through the wrap multiply, span multiply, palette read and blend register
// write words travel the same pipe and update the palette at the read stage,
// so later samples always see earlier writes in order
// reset is synchronous, active low; palette contents are undefined until written
// a stall on m_ready backs up through the valid bits; empty stages keep filling
`timescale 1ns / 1ps
`default_nettype none

module palette_gradient_sample_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input channel
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_opcode,
    input  wire logic [pgs_pkg::IDX_W-1:0]    s_entry_index,
    input  wire logic [pgs_pkg::CH_W-1:0]     s_red_in,
    input  wire logic [pgs_pkg::CH_W-1:0]     s_green_in,
    input  wire logic [pgs_pkg::CH_W-1:0]     s_blue_in,
    input  wire logic [pgs_pkg::SAMPLE_W-1:0] s_sample_value,
    // result channel
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [pgs_pkg::OUT_W-1:0]    m_packed_color,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pgs_pkg::APB_AW-1:0]   paddr,
    input  wire logic [pgs_pkg::APB_DW-1:0]   pwdata,
    output logic      [pgs_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);
    import pgs_pkg::*;

    logic [WRAP_W-1:0] wrap_reg;
    logic [SPAN_W-1:0] span_reg;
    logic              reg_sel;
    logic              cfg_write;

    in_item_t          in_item;
    map_item_t         map_item;
    logic              map_valid, map_ready;

    logic              s3_valid_reg;
    logic              s3_sample_reg;
    logic [FRAC_W-1:0] s3_frac_reg;
    logic              en3;
    logic              blend_ready;
    logic [PAL_AW-1:0] upper;
    logic [COLOR_W-1:0] color_lo, color_hi;

    // configuration registers
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_reg <= WRAP_RESET;
            span_reg <= SPAN_RESET;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_WRAP_FACTOR:    wrap_reg <= pwdata[WRAP_W-1:0];
                REG_ENTRIES_IN_USE: span_reg <= pwdata[SPAN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_WRAP_FACTOR:    prdata = APB_DW'(wrap_reg);
            REG_ENTRIES_IN_USE: prdata = APB_DW'(span_reg);
            default:            prdata = '0;
        endcase
    end

    // input word
    always_comb begin
        in_item.opcode       = s_opcode;
        in_item.entry_index  = s_entry_index;
        in_item.red          = s_red_in;
        in_item.green        = s_green_in;
        in_item.blue         = s_blue_in;
        in_item.sample_value = s_sample_value;
    end

    // stages 1 and 2: index mapping
    pgs_map u_map (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .in_item        (in_item),
        .out_valid      (map_valid),
        .out_ready      (map_ready),
        .out_item       (map_item),
        .wrap_factor    (wrap_reg),
        .entries_in_use (span_reg)
    );

    // stage 3: palette read, writes retire here; a write word leaves freely
    assign en3       = !s3_valid_reg || !s3_sample_reg || blend_ready;
    assign map_ready = en3;
    assign upper     = map_item.lower + PAL_AW'(map_item.frac != '0);

    pgs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .aclk    (aclk),
        .we      (en3 && map_valid && map_item.wr_en),
        .waddr   (map_item.wr_addr),
        .wdata   (map_item.wr_data),
        .re      (en3),
        .raddr_a (map_item.lower),
        .raddr_b (upper),
        .rdata_a (color_lo),
        .rdata_b (color_hi)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en3) begin
            s3_valid_reg <= map_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            s3_sample_reg <= map_item.is_sample;
            s3_frac_reg   <= map_item.frac;
        end
    end

    // stage 4: blend and output register
    pgs_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s3_valid_reg && s3_sample_reg),
        .in_ready  (blend_ready),
        .color_lo  (color_lo),
        .color_hi  (color_hi),
        .frac      (s3_frac_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_color (m_packed_color)
    );

    // upper neighbor always lies inside the palette
    assert property (@(posedge aclk) disable iff (!aresetn)
        map_valid |-> (32'(map_item.lower) + 32'(map_item.frac != '0) < 32'(PAL_DEPTH)))
        else $error("palette upper index out of range");

    // a stalled sample at the read stage keeps its fraction and its slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg && s3_sample_reg && !blend_ready
        |=> s3_valid_reg && s3_sample_reg && $stable(s3_frac_reg))
        else $error("read stage lost a stalled sample");

    // a new result only follows a sample at the read stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s3_valid_reg && s3_sample_reg))
        else $error("result without a sample");

endmodule

`default_nettype wire
